// ===== src/mggl_pkg.sv =====
package mggl_pkg;

    localparam int SAMPLE_W = 24;
    localparam int OUT_W    = 26;
    localparam int MAG_W    = 25;
    localparam int SUM_W    = 60;
    localparam int DB_W     = 16;
    localparam int GAIN_W   = 16;
    localparam int THR_W    = 23;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MIC_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_THR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO      = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd32768;
    localparam logic [THR_W-1:0]  THR_RESET  = 23'd83886;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 26'sd33554431;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -26'sd33554432;
    localparam logic [MAG_W-1:0] PEAK_MAX   = 25'd33554431;
    localparam logic [MAG_W-1:0] CLIP_LEVEL = 25'd7969177;
    localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
    localparam logic signed [DB_W-1:0] DB_FLOOR = -16'sd30720;
    localparam logic signed [DB_W-1:0] DB_CEIL  = 16'sd1600;
    localparam logic [MAG_W-1:0] RMS_FLOOR_CODE = 25'd8;
    localparam logic [19:0] DB_K16 = 20'd394566;

    // front-to-back entry: one classified, gated frame
    typedef struct packed {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
        logic                    gated;
        logic                    block_end;
    } mggl_entry_t;

endpackage

// ===== src/mggl_front.sv =====
module mggl_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [mggl_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [mggl_pkg::SAMPLE_W-1:0] right_in,
    input  logic                              block_end,
    input  logic [mggl_pkg::GAIN_W-1:0]       mic_gain,
    input  logic                              gate_enable,
    input  logic [mggl_pkg::THR_W-1:0]        thr_level,
    input  logic                              mono_mode,
    output logic                              ent_valid,
    input  logic                              ent_ready,
    output mggl_pkg::mggl_entry_t             ent
);

    // stage 1: gain products; stage 2: round, saturate, squares; stage 3: gate
    logic                      s1_v_reg, s2_v_reg, s3_v_reg;
    logic signed [40:0]        s1_lp_reg, s1_rp_reg;
    logic                      s1_end_reg, s1_mono_reg;
    logic signed [mggl_pkg::OUT_W-1:0] s2_l_reg, s2_r_reg;
    logic [49:0]               s2_l2_reg, s2_r2_reg;
    logic [45:0]               s2_t2_reg;
    logic                      s2_end_reg, s2_mono_reg, s2_ge_reg;
    mggl_pkg::mggl_entry_t     s3_reg;

    logic [mggl_pkg::GAIN_W-1:0] g;
    logic signed [mggl_pkg::OUT_W-1:0] l_sat, r_sat, r_use;
    logic [mggl_pkg::OUT_W-1:0] l_abs, r_abs;
    logic gated;
    logic busy;

    function automatic logic signed [mggl_pkg::OUT_W-1:0] rnd_sat(input logic signed [40:0] p);
        logic signed [41:0] q;
        logic signed [27:0] r;
        begin
            q = 42'(p) + 42'sd8192;
            r = 28'(q >>> 14);
            if (r > 28'(mggl_pkg::OUT_MAX)) rnd_sat = mggl_pkg::OUT_MAX;
            else if (r < 28'(mggl_pkg::OUT_MIN)) rnd_sat = mggl_pkg::OUT_MIN;
            else rnd_sat = r[mggl_pkg::OUT_W-1:0];
        end
    endfunction

    assign busy = s1_v_reg || s2_v_reg || s3_v_reg;
    assign in_ready = !busy;
    assign g = (mic_gain > mggl_pkg::GAIN_MAX) ? mggl_pkg::GAIN_MAX : mic_gain;
    assign l_sat = rnd_sat(s1_lp_reg);
    assign r_sat = rnd_sat(s1_rp_reg);
    assign r_use = s1_mono_reg ? l_sat : r_sat;
    assign l_abs = l_sat[mggl_pkg::OUT_W-1] ? -l_sat : l_sat;
    assign r_abs = r_use[mggl_pkg::OUT_W-1] ? -r_use : r_use;

    always_comb begin
        if (!s2_ge_reg) gated = 1'b0;
        else if (s2_mono_reg) gated = 51'(s2_l2_reg) < 51'(s2_t2_reg);
        else gated = (51'(s2_l2_reg) + 51'(s2_r2_reg)) < {4'd0, s2_t2_reg, 1'b0};
    end

    assign ent_valid = s3_v_reg;
    assign ent = s3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= in_valid && in_ready;
            s2_v_reg <= s1_v_reg;
            if (s2_v_reg) s3_v_reg <= 1'b1;
            else if (ent_ready) s3_v_reg <= 1'b0;
        end
        if (in_valid && in_ready) begin
            s1_lp_reg <= 41'(left_in) * $signed({1'b0, g});
            s1_rp_reg <= 41'(right_in) * $signed({1'b0, g});
            s1_end_reg <= block_end;
            s1_mono_reg <= mono_mode;
        end
        if (s1_v_reg) begin
            s2_l_reg <= l_sat;
            s2_r_reg <= r_use;
            s2_l2_reg <= l_abs[24:0] * l_abs[24:0];
            s2_r2_reg <= r_abs[24:0] * r_abs[24:0];
            s2_t2_reg <= thr_level * thr_level;
            s2_end_reg <= s1_end_reg;
            s2_mono_reg <= s1_mono_reg;
            s2_ge_reg <= gate_enable;
        end
        if (s2_v_reg) begin
            s3_reg.left <= gated ? '0 : s2_l_reg;
            s3_reg.right <= gated ? '0 : s2_r_reg;
            s3_reg.gated <= gated;
            s3_reg.block_end <= s2_end_reg;
        end
    end

endmodule

// ===== src/mggl_queue.sv =====
module mggl_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  mggl_pkg::mggl_entry_t wr_data,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output mggl_pkg::mggl_entry_t rd_data
);

    mggl_pkg::mggl_entry_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_valid && wr_ready) wp_reg <= !wp_reg;
            if (rd_valid && rd_ready) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
        if (wr_valid && wr_ready) mem_reg[wp_reg] <= wr_data;
    end

endmodule

// ===== src/mggl_back.sv =====
module mggl_back #(
    parameter int MAX_BLOCK_FRAMES = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ent_valid,
    output logic                  ent_ready,
    input  mggl_pkg::mggl_entry_t ent,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [mggl_pkg::OUT_W-1:0] m_left_out,
    output logic signed [mggl_pkg::OUT_W-1:0] m_right_out,
    output logic                  m_frame_gated,
    output logic                  m_levels_valid,
    output logic [mggl_pkg::MAG_W-1:0] m_left_peak,
    output logic [mggl_pkg::MAG_W-1:0] m_right_peak,
    output logic [mggl_pkg::MAG_W-1:0] m_left_rms,
    output logic [mggl_pkg::MAG_W-1:0] m_right_rms,
    output logic signed [mggl_pkg::DB_W-1:0] m_left_level_db,
    output logic signed [mggl_pkg::DB_W-1:0] m_right_level_db,
    output logic                  m_clip_flag,
    output logic                  m_result_last
);

    localparam int CNT_W = $clog2(MAX_BLOCK_FRAMES + 1);
    localparam int SW = mggl_pkg::SUM_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQ, ST_ACC, ST_DIV, ST_SQRT, ST_LOG, ST_OUT
    } state_t;

    state_t state_reg;
    logic [mggl_pkg::MAG_W-1:0] lpk_reg, rpk_reg;
    logic [SW-1:0] lsum_reg, rsum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [49:0] lsq_reg, rsq_reg;
    mggl_pkg::mggl_entry_t cur_reg;
    logic done_reg;
    logic ch_reg;
    logic [6:0] step_reg;
    logic [SW-1:0] quo_reg, rem_reg, num_reg;
    logic [SW-1:0] x_reg, root_reg, bit_reg;
    logic [mggl_pkg::MAG_W-1:0] lrms_reg, rrms_reg;
    logic [4:0] e_reg;
    logic [32:0] m_reg;
    logic [15:0] l2_reg;
    logic [4:0] sq_step_reg;
    logic signed [mggl_pkg::DB_W-1:0] ldb_reg, rdb_reg;
    logic ovalid_reg;

    logic [mggl_pkg::MAG_W-1:0] lm, rm, cur_rms;
    logic [SW:0] lsum_add, rsum_add;
    logic [CNT_W:0] n;
    logic [SW:0] rem_sh;
    logic [SW:0] trial;
    logic [65:0] msq;
    logic [32:0] msh;
    logic [4:0] e_find;
    logic signed [22:0] l2_full;
    logic signed [43:0] db_prod;
    logic signed [27:0] db_val;
    logic signed [mggl_pkg::DB_W-1:0] db_clamped;

    assign lm = cur_reg.left[mggl_pkg::OUT_W-1] ? mggl_pkg::MAG_W'(-cur_reg.left)
                                                 : cur_reg.left[mggl_pkg::MAG_W-1:0];
    assign rm = cur_reg.right[mggl_pkg::OUT_W-1] ? mggl_pkg::MAG_W'(-cur_reg.right)
                                                  : cur_reg.right[mggl_pkg::MAG_W-1:0];
    assign lsum_add = {1'b0, lsum_reg} + (SW+1)'(lsq_reg);
    assign rsum_add = {1'b0, rsum_reg} + (SW+1)'(rsq_reg);
    assign n = {1'b0, cnt_reg} + (CNT_W+1)'(1);

    assign rem_sh = {rem_reg, num_reg[SW-1]};
    assign trial = {1'b0, x_reg} - ({1'b0, root_reg} + {1'b0, bit_reg});

    assign cur_rms = ch_reg ? rrms_reg : lrms_reg;
    always_comb begin
        e_find = 5'd0;
        for (int i = 1; i < mggl_pkg::MAG_W; i++) begin
            if (cur_rms[i]) e_find = 5'(i);
        end
    end
    assign msq = m_reg * m_reg;
    assign msh = 33'(msq >> 30);
    assign l2_full = $signed({7'd0, l2_reg}) + $signed({1'b0, e_reg, 16'd0})
                     - 23'sd1507328;
    assign db_prod = 44'(l2_full) * $signed({1'b0, mggl_pkg::DB_K16}) + 44'sd8388608;
    assign db_val = 28'(db_prod >>> 24);
    always_comb begin
        if (db_val < 28'(mggl_pkg::DB_FLOOR)) db_clamped = mggl_pkg::DB_FLOOR;
        else if (db_val > 28'(mggl_pkg::DB_CEIL)) db_clamped = mggl_pkg::DB_CEIL;
        else db_clamped = db_val[mggl_pkg::DB_W-1:0];
    end

    assign ent_ready = (state_reg == ST_IDLE) && !(ovalid_reg && !m_ready);
    assign m_valid = ovalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ovalid_reg <= 1'b0;
            lpk_reg <= '0;
            rpk_reg <= '0;
            lsum_reg <= '0;
            rsum_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (ovalid_reg && m_ready) ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (ent_valid && ent_ready) begin
                        cur_reg <= ent;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    lsq_reg <= lm * lm;
                    rsq_reg <= rm * rm;
                    if (lm > lpk_reg) lpk_reg <= lm;
                    if (rm > rpk_reg) rpk_reg <= rm;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    lsum_reg <= lsum_add[SW] ? mggl_pkg::SUM_MAX : lsum_add[SW-1:0];
                    rsum_reg <= rsum_add[SW] ? mggl_pkg::SUM_MAX : rsum_add[SW-1:0];
                    done_reg <= cur_reg.block_end || (n >= (CNT_W+1)'(MAX_BLOCK_FRAMES));
                    if (cur_reg.block_end || (n >= (CNT_W+1)'(MAX_BLOCK_FRAMES))) begin
                        ch_reg <= 1'b0;
                        step_reg <= '0;
                        rem_reg <= '0;
                        num_reg <= lsum_add[SW] ? mggl_pkg::SUM_MAX : lsum_add[SW-1:0];
                        state_reg <= ST_DIV;
                    end else begin
                        cnt_reg <= n[CNT_W-1:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    if (rem_sh >= (SW+1)'(n)) begin
                        rem_reg <= SW'(rem_sh - (SW+1)'(n));
                        quo_reg <= {quo_reg[SW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[SW-1:0];
                        quo_reg <= {quo_reg[SW-2:0], 1'b0};
                    end
                    num_reg <= {num_reg[SW-2:0], 1'b0};
                    if (step_reg == 7'(SW - 1)) begin
                        step_reg <= '0;
                        state_reg <= ST_SQRT;
                        x_reg <= (rem_sh >= (SW+1)'(n))
                                 ? {quo_reg[SW-2:0], 1'b1} : {quo_reg[SW-2:0], 1'b0};
                        root_reg <= '0;
                        bit_reg <= SW'(1) << (SW - 2);
                    end else begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_SQRT: begin
                    if (!trial[SW]) begin
                        x_reg <= trial[SW-1:0];
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        if (ch_reg) rrms_reg <= (!trial[SW]) ? mggl_pkg::MAG_W'((root_reg >> 1) + bit_reg)
                                                             : mggl_pkg::MAG_W'(root_reg >> 1);
                        else lrms_reg <= (!trial[SW]) ? mggl_pkg::MAG_W'((root_reg >> 1) + bit_reg)
                                                      : mggl_pkg::MAG_W'(root_reg >> 1);
                        sq_step_reg <= '0;
                        l2_reg <= '0;
                        state_reg <= ST_LOG;
                        e_reg <= '0;
                        m_reg <= '0;
                    end
                end
                ST_LOG: begin
                    if (sq_step_reg == 5'd0) begin
                        e_reg <= e_find;
                        m_reg <= 33'(({8'd0, cur_rms} << (5'd30 - e_find)));
                        sq_step_reg <= 5'd1;
                    end else if (sq_step_reg <= 5'd16) begin
                        if (msh[31] || msh[32]) begin
                            m_reg <= msh >> 1;
                            l2_reg <= {l2_reg[14:0], 1'b1};
                        end else begin
                            m_reg <= msh;
                            l2_reg <= {l2_reg[14:0], 1'b0};
                        end
                        sq_step_reg <= sq_step_reg + 5'd1;
                    end else begin
                        if (ch_reg) rdb_reg <= (cur_rms <= mggl_pkg::RMS_FLOOR_CODE)
                                               ? mggl_pkg::DB_FLOOR : db_clamped;
                        else ldb_reg <= (cur_rms <= mggl_pkg::RMS_FLOOR_CODE)
                                        ? mggl_pkg::DB_FLOOR : db_clamped;
                        if (ch_reg) begin
                            state_reg <= ST_OUT;
                        end else begin
                            ch_reg <= 1'b1;
                            step_reg <= '0;
                            rem_reg <= '0;
                            quo_reg <= '0;
                            num_reg <= rsum_reg;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_OUT: begin
                    if (!ovalid_reg || m_ready) begin
                        ovalid_reg <= 1'b1;
                        m_left_out <= cur_reg.left;
                        m_right_out <= cur_reg.right;
                        m_frame_gated <= cur_reg.gated;
                        m_result_last <= cur_reg.block_end;
                        m_levels_valid <= done_reg;
                        m_left_peak <= done_reg ? lpk_reg : '0;
                        m_right_peak <= done_reg ? rpk_reg : '0;
                        m_left_rms <= done_reg ? lrms_reg : '0;
                        m_right_rms <= done_reg ? rrms_reg : '0;
                        m_left_level_db <= done_reg ? ldb_reg : '0;
                        m_right_level_db <= done_reg ? rdb_reg : '0;
                        m_clip_flag <= done_reg &&
                            (lpk_reg > mggl_pkg::CLIP_LEVEL || rpk_reg > mggl_pkg::CLIP_LEVEL);
                        if (done_reg) begin
                            lpk_reg <= '0;
                            rpk_reg <= '0;
                            lsum_reg <= '0;
                            rsum_reg <= '0;
                            cnt_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== src/mic_gain_gate_level_meter.sv =====
// A block's last frame also runs, per channel, a bit-serial divide of the
// square sum by frame count, up to 30 root steps and 18 log steps.
// Front end and metering unit each accept a frame only after the last one.
// Reset: synchronous, active low; registers return to their reset values and
// the peak and square-sum accumulators clear.
module mic_gain_gate_level_meter #(
    parameter int MAX_BLOCK_FRAMES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [mggl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mggl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [23:0] s_left_in,
    input  logic signed [23:0] s_right_in,
    input  logic        s_block_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [25:0] m_left_out,
    output logic signed [25:0] m_right_out,
    output logic        m_frame_gated,
    output logic        m_levels_valid,
    output logic [24:0] m_left_peak,
    output logic [24:0] m_right_peak,
    output logic [24:0] m_left_rms,
    output logic [24:0] m_right_rms,
    output logic signed [15:0] m_left_level_db,
    output logic signed [15:0] m_right_level_db,
    output logic        m_clip_flag,
    output logic        m_result_last
);

    logic [mggl_pkg::GAIN_W-1:0] gain_reg;
    logic gate_en_reg, mono_reg;
    logic [mggl_pkg::THR_W-1:0] thr_reg;
    logic fe_valid, fe_ready, q_valid, q_ready;
    mggl_pkg::mggl_entry_t fe_ent, q_ent;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= mggl_pkg::GAIN_RESET;
            gate_en_reg <= 1'b1;
            thr_reg <= mggl_pkg::THR_RESET;
            mono_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                mggl_pkg::CFG_MIC_GAIN: gain_reg <= cfg_data[mggl_pkg::GAIN_W-1:0];
                mggl_pkg::CFG_GATE_EN:  gate_en_reg <= cfg_data[0];
                mggl_pkg::CFG_GATE_THR: thr_reg <= cfg_data[mggl_pkg::THR_W-1:0];
                mggl_pkg::CFG_MONO:     mono_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mggl_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .left_in(s_left_in), .right_in(s_right_in), .block_end(s_block_end),
        .mic_gain(gain_reg), .gate_enable(gate_en_reg),
        .thr_level(thr_reg), .mono_mode(mono_reg),
        .ent_valid(fe_valid), .ent_ready(fe_ready), .ent(fe_ent)
    );

    mggl_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fe_valid), .wr_ready(fe_ready), .wr_data(fe_ent),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_ent)
    );

    mggl_back #(.MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .ent_valid(q_valid), .ent_ready(q_ready), .ent(q_ent),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_left_out(m_left_out), .m_right_out(m_right_out),
        .m_frame_gated(m_frame_gated), .m_levels_valid(m_levels_valid),
        .m_left_peak(m_left_peak), .m_right_peak(m_right_peak),
        .m_left_rms(m_left_rms), .m_right_rms(m_right_rms),
        .m_left_level_db(m_left_level_db), .m_right_level_db(m_right_level_db),
        .m_clip_flag(m_clip_flag), .m_result_last(m_result_last)
    );

endmodule
